>>> sv/ljpf_pkg.sv
`timescale 1ns / 1ps
package ljpf_pkg;

   // quotient width of the Q32.32 dividers
   localparam int unsigned QUO_W = 64;

   // 2^(1/3) in Q1.30
   localparam logic [30:0] CUBE_ROOT_TWO_Q30 = 31'd1352829926;

   // largest positive Q16.16 magnitude
   localparam logic [30:0] POS_MAX_31 = 31'h7FFF_FFFF;

   // one in Q32.32
   localparam logic [63:0] ONE_Q32 = 64'h0000_0001_0000_0000;

   // configuration register indexes
   typedef enum logic {
      REG_LENGTH_SCALE = 1'b0,
      REG_WELL_DEPTH   = 1'b1
   } reg_index_type;

   // item payload carried through the distance divider
   typedef struct packed {
      logic [2:0]       sign;
      logic [2:0][31:0] mag;
      logic [47:0]      d2;
      logic             in_cut;
      logic             d2_sat;
      logic             ovf;
   } div_side_type;

   // item payload behind the divider
   typedef struct packed {
      logic [2:0]       sign;
      logic [2:0][31:0] mag;
      logic [47:0]      d2;
      logic             in_cut;
      logic             d2_sat;
      logic             isat;
      logic [63:0]      s;
      logic [63:0]      s4;
      logic [30:0]      pot;
      logic [30:0]      fs;
      logic [2:0][62:0] fprod;
   } item_type;

   // saturating Q32.32 product
   typedef struct packed {
      logic [63:0] prod;
      logic        sat;
   } mul_res_type;

   // one result item
   typedef struct packed {
      logic [31:0] fx;
      logic [31:0] fy;
      logic [31:0] fz;
      logic [31:0] fs;
      logic [47:0] d2;
      logic [31:0] pot;
      logic        in_cut;
      logic        sat;
   } rsp_type;

endpackage

>>> sv/ljpf_mul.sv
`timescale 1ns / 1ps
// Two-stage saturating Q32.32 multiply: (a * b) >> 32, clipped at all ones.
module ljpf_mul (
   input  logic                      clock,
   input  logic                      en,
   input  logic [63:0]               a,
   input  logic [63:0]               b,
   output ljpf_pkg::mul_res_type     res
);

   logic [63:0] ll_ff, lh_ff, hl_ff, hh_ff;
   logic [127:0] full;
   ljpf_pkg::mul_res_type res_in, res_ff;

   // partial products
   always_ff @(posedge clock) begin
      if (en) begin
         ll_ff <= 64'(a[31:0]) * 64'(b[31:0]);
         lh_ff <= 64'(a[31:0]) * 64'(b[63:32]);
         hl_ff <= 64'(a[63:32]) * 64'(b[31:0]);
         hh_ff <= 64'(a[63:32]) * 64'(b[63:32]);
      end
   end

   // sum, shift and clip
   always_comb begin
      full = {hh_ff, 64'd0} + {32'd0, lh_ff, 32'd0} + {32'd0, hl_ff, 32'd0} + {64'd0, ll_ff};
      res_in.sat  = |full[127:96];
      res_in.prod = res_in.sat ? {64{1'b1}} : full[95:32];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

>>> sv/ljpf_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, one quotient bit per stage.
// The start remainder must be below the divisor; overflow is judged outside.
module ljpf_div #(
   parameter int unsigned DEN_W  = 47,
   parameter int unsigned SIDE_W = 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic                        start_vld,
   input  logic [DEN_W-1:0]            start_rem,
   input  logic [ljpf_pkg::QUO_W-1:0]  start_low,
   input  logic [DEN_W-1:0]            start_den,
   input  logic [SIDE_W-1:0]           start_side,
   output logic                        done_vld,
   output logic [ljpf_pkg::QUO_W-1:0]  done_quo,
   output logic [SIDE_W-1:0]           done_side
);

   localparam int unsigned STAGES = ljpf_pkg::QUO_W;

   logic [STAGES-1:0] vld_ff;
   logic [DEN_W-1:0] rem_ff [STAGES];
   logic [DEN_W-1:0] rem_in [STAGES];
   logic [ljpf_pkg::QUO_W-1:0] lq_ff [STAGES];
   logic [ljpf_pkg::QUO_W-1:0] lq_in [STAGES];
   logic [DEN_W-1:0] den_ff [STAGES];
   logic [SIDE_W-1:0] side_ff [STAGES];

   logic [DEN_W-1:0] rem_cur [STAGES];
   logic [ljpf_pkg::QUO_W-1:0] lq_cur [STAGES];
   logic [DEN_W-1:0] den_cur [STAGES];
   logic [SIDE_W-1:0] side_cur [STAGES];

   // stage inputs: dividend bits shift out of lq at the top, quotient bits in at the bottom
   always_comb begin
      logic [DEN_W:0] r2;
      logic [DEN_W:0] sub;
      logic           qb;
      rem_cur[0]  = start_rem;
      lq_cur[0]   = start_low;
      den_cur[0]  = start_den;
      side_cur[0] = start_side;
      for (int k = 1; k < STAGES; k++) begin
         rem_cur[k]  = rem_ff[k-1];
         lq_cur[k]   = lq_ff[k-1];
         den_cur[k]  = den_ff[k-1];
         side_cur[k] = side_ff[k-1];
      end
      for (int k = 0; k < STAGES; k++) begin
         r2  = {rem_cur[k], lq_cur[k][ljpf_pkg::QUO_W-1]};
         sub = r2 - {1'b0, den_cur[k]};
         if (r2 >= {1'b0, den_cur[k]}) begin
            rem_in[k] = sub[DEN_W-1:0];
            qb        = 1'b1;
         end else begin
            rem_in[k] = r2[DEN_W-1:0];
            qb        = 1'b0;
         end
         lq_in[k] = {lq_cur[k][ljpf_pkg::QUO_W-2:0], qb};
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[STAGES-2:0], start_vld};
      end
   end

   // stage data
   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < STAGES; k++) begin
            rem_ff[k]  <= rem_in[k];
            lq_ff[k]   <= lq_in[k];
            den_ff[k]  <= den_cur[k];
            side_ff[k] <= side_cur[k];
         end
      end
   end

   assign done_vld  = vld_ff[STAGES-1];
   assign done_quo  = lq_ff[STAGES-1];
   assign done_side = side_ff[STAGES-1];

endmodule

>>> sv/lennard_jones_pair_force.sv
`timescale 1ns / 1ps
// Lennard-Jones pair force with the WCA cutoff, Q16.16 fixed point. The block takes one
// particle pair per cycle while req_ready is high; each pair passes through the 64-stage
// pipelined divider that forms s = sigma^2/r^2, followed by eight two-stage saturating
// multipliers for the powers of s, the force scale and the potential.
// A result waiting at the output does not stop intake at once: a one-item skid buffer lets
// the pipeline move one more step, and only then is req_ready dropped. The coefficient
// 48*eps/sigma^2 comes from a second, free-running divider fed by the configuration
// registers; write them only with the block drained. No clearing pass is needed after reset.
module lennard_jones_pair_force (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [31:0] req_first_x,
   input  logic signed [31:0] req_first_y,
   input  logic signed [31:0] req_first_z,
   input  logic signed [31:0] req_second_x,
   input  logic signed [31:0] req_second_y,
   input  logic signed [31:0] req_second_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_force_x,
   output logic signed [31:0] rsp_force_y,
   output logic signed [31:0] rsp_force_z,
   output logic signed [31:0] rsp_force_scale,
   output logic [47:0]        rsp_distance_squared,
   output logic signed [31:0] rsp_pair_potential,
   output logic               rsp_inside_cutoff,
   output logic               rsp_saturated,
   input  logic               csr_write,
   input  logic               csr_index,
   input  logic [30:0]        csr_wdata
);

   localparam int unsigned POST = 13;
   localparam int unsigned SIDE_W = $bits(ljpf_pkg::div_side_type);

   logic en;

   // ---------------- configuration and derived constants ----------------
   logic [30:0] length_ff, depth_ff;
   logic [61:0] sig2_ff;
   logic [61:0] rc_lo_ff, rc_hi_ff;
   logic [92:0] rc_full;
   logic [46:0] rc2_ff;
   logic [36:0] num;
   logic        coef_ovf;
   logic        coef_vld;
   logic [63:0] coef_quo;
   logic [0:0]  coef_side;
   logic [63:0] coef_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= 31'd65536;
         depth_ff  <= 31'd65536;
      end else if (csr_write) begin
         case (ljpf_pkg::reg_index_type'(csr_index))
            ljpf_pkg::REG_LENGTH_SCALE: length_ff <= csr_wdata;
            ljpf_pkg::REG_WELL_DEPTH:   depth_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // sigma^2 and the squared cutoff, in register steps
   assign rc_full = {rc_hi_ff, 31'd0} + 93'(rc_lo_ff);

   always_ff @(posedge clock) begin
      sig2_ff  <= 62'(length_ff) * 62'(length_ff);
      rc_lo_ff <= 62'(sig2_ff[30:0]) * 62'(ljpf_pkg::CUBE_ROOT_TWO_Q30);
      rc_hi_ff <= 62'(sig2_ff[61:31]) * 62'(ljpf_pkg::CUBE_ROOT_TWO_Q30);
      rc2_ff   <= rc_full[92:46];
   end

   // coefficient 48*eps/sigma^2 in Q32.32
   assign num      = {1'b0, depth_ff, 5'd0} + {2'b0, depth_ff, 4'd0};
   assign coef_ovf = 62'(num[36:16]) >= sig2_ff;
   assign coef_val = coef_side[0] ? {64{1'b1}} : coef_quo;

   ljpf_div #(
      .DEN_W  (62),
      .SIDE_W (1)
   ) u_coef_div (
      .clock      (clock),
      .reset      (reset),
      .en         (1'b1),
      .start_vld  (1'b1),
      .start_rem  (62'(num[36:16])),
      .start_low  ({num[15:0], 48'd0}),
      .start_den  (sig2_ff),
      .start_side (coef_ovf),
      .done_vld   (coef_vld),
      .done_quo   (coef_quo),
      .done_side  (coef_side)
   );

   // ---------------- front stages: difference, squares, distance ----------------
   logic [2:0][31:0] pos_a, pos_b;
   logic [2:0][32:0] diff;
   logic [2:0]       sign_in;
   logic [2:0][31:0] mag_in;

   logic             p1_vld_ff, p2_vld_ff, p3_vld_ff, p4_vld_ff;
   logic [2:0]       p1_sign_ff, p2_sign_ff, p3_sign_ff;
   logic [2:0][31:0] p1_mag_ff, p2_mag_ff, p3_mag_ff;
   logic [2:0][63:0] p2_sq_ff;
   logic [65:0]      sq_sum;
   logic [49:0]      p3_d2_ff;
   ljpf_pkg::div_side_type p4_in, p4_ff;

   assign pos_a = {req_first_z, req_first_y, req_first_x};
   assign pos_b = {req_second_z, req_second_y, req_second_x};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         diff[k]    = {pos_a[k][31], pos_a[k]} - {pos_b[k][31], pos_b[k]};
         sign_in[k] = diff[k][32];
         mag_in[k]  = sign_in[k] ? 32'(33'd0 - diff[k]) : diff[k][31:0];
      end
   end

   assign sq_sum = 66'(p2_sq_ff[0]) + 66'(p2_sq_ff[1]) + 66'(p2_sq_ff[2]);

   // cutoff test and divider setup
   always_comb begin
      p4_in.sign   = p3_sign_ff;
      p4_in.mag    = p3_mag_ff;
      p4_in.d2_sat = |p3_d2_ff[49:48];
      p4_in.d2     = p4_in.d2_sat ? {48{1'b1}} : p3_d2_ff[47:0];
      p4_in.in_cut = p3_d2_ff < 50'(rc2_ff);
      p4_in.ovf    = 47'(sig2_ff[61:48]) >= p3_d2_ff[46:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_vld_ff <= 1'b0;
         p2_vld_ff <= 1'b0;
         p3_vld_ff <= 1'b0;
         p4_vld_ff <= 1'b0;
      end else if (en) begin
         p1_vld_ff <= req_valid;
         p2_vld_ff <= p1_vld_ff;
         p3_vld_ff <= p2_vld_ff;
         p4_vld_ff <= p3_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p1_sign_ff <= sign_in;
         p1_mag_ff  <= mag_in;
         p2_sign_ff <= p1_sign_ff;
         p2_mag_ff  <= p1_mag_ff;
         for (int k = 0; k < 3; k++) begin
            p2_sq_ff[k] <= 64'(p1_mag_ff[k]) * 64'(p1_mag_ff[k]);
         end
         p3_sign_ff <= p2_sign_ff;
         p3_mag_ff  <= p2_mag_ff;
         p3_d2_ff   <= sq_sum[65:16];
         p4_ff      <= p4_in;
      end
   end

   // ---------------- s = sigma^2 / d2 ----------------
   logic                   div_vld;
   logic [63:0]            div_quo;
   logic [SIDE_W-1:0]      div_side_raw;
   ljpf_pkg::div_side_type dside;

   ljpf_div #(
      .DEN_W  (47),
      .SIDE_W (SIDE_W)
   ) u_dist_div (
      .clock      (clock),
      .reset      (reset),
      .en         (en),
      .start_vld  (p4_vld_ff),
      .start_rem  (47'(sig2_ff[61:48])),
      .start_low  ({sig2_ff[47:0], 16'd0}),
      .start_den  (p4_ff.d2[46:0]),
      .start_side (p4_ff),
      .done_vld   (div_vld),
      .done_quo   (div_quo),
      .done_side  (div_side_raw)
   );

   assign dside = div_side_raw;

   // ---------------- back stages: powers, force scale, potential ----------------
   ljpf_pkg::item_type item_ff [1:POST];
   ljpf_pkg::item_type item_in [1:POST];
   logic [POST:1]      ivld_ff;

   ljpf_pkg::mul_res_type m1, m2, m3, m4, m5, m6, m7, m8;
   logic [63:0] w_val;
   logic        w_sat;
   logic [63:0] t_val;
   logic [63:0] half_s4;
   logic [63:0] dbl_s3;

   // w = |2*s^3 - 1|
   always_comb begin
      dbl_s3 = {m2.prod[62:0], 1'b0};
      w_sat  = m2.prod[63];
      if (w_sat) begin
         w_val = {64{1'b1}};
      end else if (dbl_s3 >= ljpf_pkg::ONE_Q32) begin
         w_val = dbl_s3 - ljpf_pkg::ONE_Q32;
      end else begin
         w_val = ljpf_pkg::ONE_Q32 - dbl_s3;
      end
   end

   // s^7 - s^4/2, clamped at zero
   assign half_s4 = item_ff[9].s4 >> 1;
   assign t_val   = (m6.prod > half_s4) ? m6.prod - half_s4 : 64'd0;

   ljpf_mul u_m1 (.clock(clock), .en(en), .a(item_ff[1].s), .b(item_ff[1].s), .res(m1));
   ljpf_mul u_m2 (.clock(clock), .en(en), .a(m1.prod),      .b(item_ff[3].s), .res(m2));
   ljpf_mul u_m3 (.clock(clock), .en(en), .a(m2.prod),      .b(item_ff[5].s), .res(m3));
   ljpf_mul u_m4 (.clock(clock), .en(en), .a(m2.prod),      .b(m2.prod),      .res(m4));
   ljpf_mul u_m5 (.clock(clock), .en(en), .a(w_val),        .b(w_val),        .res(m5));
   ljpf_mul u_m6 (.clock(clock), .en(en), .a(m4.prod),      .b(item_ff[7].s), .res(m6));
   ljpf_mul u_m7 (.clock(clock), .en(en), .a({33'd0, depth_ff}), .b(m5.prod), .res(m7));
   ljpf_mul u_m8 (.clock(clock), .en(en), .a(coef_val),     .b(t_val),        .res(m8));

   always_comb begin
      logic [47:0] f48;
      item_in[1]        = '0;
      item_in[1].sign   = dside.sign;
      item_in[1].mag    = dside.mag;
      item_in[1].d2     = dside.d2;
      item_in[1].in_cut = dside.in_cut;
      item_in[1].d2_sat = dside.d2_sat;
      item_in[1].isat   = dside.ovf;
      item_in[1].s      = dside.ovf ? {64{1'b1}} : div_quo;
      for (int k = 2; k <= POST; k++) begin
         item_in[k] = item_ff[k-1];
      end
      // s^2 ready
      item_in[4].isat = item_ff[3].isat | m1.sat;
      // s^3 ready, w formed
      item_in[6].isat = item_ff[5].isat | m2.sat | w_sat;
      // s^4, s^6, w^2 ready
      item_in[8].s4   = m3.prod;
      item_in[8].isat = item_ff[7].isat | m3.sat | m4.sat | m5.sat;
      // s^7 and eps*w^2 ready
      item_in[10].pot  = (|m7.prod[63:31]) ? ljpf_pkg::POS_MAX_31 : m7.prod[30:0];
      item_in[10].isat = item_ff[9].isat | m6.sat | m7.sat | (|m7.prod[63:31]) | coef_side[0];
      // force scale
      f48              = m8.prod[63:16];
      item_in[12].fs   = (|f48[47:31]) ? ljpf_pkg::POS_MAX_31 : f48[30:0];
      item_in[12].isat = item_ff[11].isat | m8.sat | (|f48[47:31]);
      // force products
      for (int k = 0; k < 3; k++) begin
         item_in[13].fprod[k] = 63'(item_ff[12].fs) * 63'(item_ff[12].mag[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ivld_ff <= '0;
      end else if (en) begin
         ivld_ff <= {ivld_ff[POST-1:1], div_vld};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 1; k <= POST; k++) begin
            item_ff[k] <= item_in[k];
         end
      end
   end

   // ---------------- result assembly ----------------
   ljpf_pkg::rsp_type fin;
   logic [2:0][31:0]  comp;
   logic              clip_any;

   always_comb begin
      logic [46:0] q;
      logic [46:0] neg;
      fin      = '0;
      clip_any = 1'b0;
      for (int k = 0; k < 3; k++) begin
         q   = item_ff[POST].fprod[k][62:16];
         neg = 47'd0 - q;
         if (item_ff[POST].sign[k]) begin
            if (q > 47'h0000_8000_0000) begin
               clip_any = 1'b1;
               comp[k]  = 32'h8000_0000;
            end else begin
               comp[k] = neg[31:0];
            end
         end else if (q > 47'h0000_7FFF_FFFF) begin
            clip_any = 1'b1;
            comp[k]  = 32'h7FFF_FFFF;
         end else begin
            comp[k] = q[31:0];
         end
      end
      fin.d2     = item_ff[POST].d2;
      fin.in_cut = item_ff[POST].in_cut;
      if (item_ff[POST].in_cut) begin
         fin.fx  = comp[0];
         fin.fy  = comp[1];
         fin.fz  = comp[2];
         fin.fs  = {1'b0, item_ff[POST].fs};
         fin.pot = {1'b0, item_ff[POST].pot};
      end
      fin.sat = item_ff[POST].d2_sat |
                (item_ff[POST].in_cut & (item_ff[POST].isat | clip_any));
   end

   // ---------------- output register with skid ----------------
   logic              rsp_vld_ff, skid_vld_ff;
   ljpf_pkg::rsp_type rsp_data_ff, skid_data_ff;

   assign en        = !skid_vld_ff;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (!rsp_vld_ff || rsp_ready) begin
         if (skid_vld_ff) begin
            rsp_vld_ff  <= 1'b1;
            skid_vld_ff <= 1'b0;
         end else begin
            rsp_vld_ff <= ivld_ff[POST];
         end
      end else if (en && ivld_ff[POST]) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_vld_ff || rsp_ready) begin
         rsp_data_ff <= skid_vld_ff ? skid_data_ff : fin;
      end else if (en && ivld_ff[POST]) begin
         skid_data_ff <= fin;
      end
   end

   assign rsp_valid            = rsp_vld_ff;
   assign rsp_force_x          = rsp_data_ff.fx;
   assign rsp_force_y          = rsp_data_ff.fy;
   assign rsp_force_z          = rsp_data_ff.fz;
   assign rsp_force_scale      = rsp_data_ff.fs;
   assign rsp_distance_squared = rsp_data_ff.d2;
   assign rsp_pair_potential   = rsp_data_ff.pot;
   assign rsp_inside_cutoff    = rsp_data_ff.in_cut;
   assign rsp_saturated        = rsp_data_ff.sat;

   // ---------------- assertions ----------------
   // coefficient pipe has filled before any item needs it
   a_coef_filled: assert property (@(posedge clock) disable iff (reset)
      ivld_ff[9] |-> coef_vld)
      else $error("coefficient divider empty when an item reached it");

   // skid only loads behind a held result
   a_skid_load: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_vld_ff) |-> $past(rsp_vld_ff && !rsp_ready))
      else $error("skid loaded while output was free");

   // a nonzero force scale or potential only comes from inside the cutoff
   a_force_inside: assert property (@(posedge clock) disable iff (reset)
      (rsp_vld_ff && (rsp_data_ff.fs != 32'd0 || rsp_data_ff.pot != 32'd0))
         |-> rsp_data_ff.in_cut)
      else $error("nonzero force or potential outside the cutoff");

endmodule

>>> tb/tb_lennard_jones_pair_force.sv
`timescale 1ns / 1ps
module tb_lennard_jones_pair_force;

   localparam int unsigned CYCLE_LIMIT = 600000;
   // wait that covers the pipeline depth and the coefficient divider's refill after a write
   localparam int unsigned SETTLE = 200;
   localparam logic [30:0] Q_ONE = 31'd65536;
   localparam logic [30:0] REG_MAX = 31'h7FFF_FFFF;

   // expected force results, computed from accepted pairs
   class ljpf_scoreboard;
      logic [30:0]       sigma;
      logic [30:0]       depth;
      ljpf_pkg::rsp_type force_q[$];
      int                errors;
      int                checked;
      int                inside_seen;
      int                sat_seen;
      bit                clip;

      function new();
         sigma = Q_ONE;
         depth = Q_ONE;
      endfunction

      // Q32.32 product, truncated, saturating at all ones
      function logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
         logic [127:0] p;
         p = a * b;
         if (p[127:96] != 0) begin
            clip = 1;
            return '1;
         end
         return p[95:32];
      endfunction

      function logic [63:0] div_q32(logic [127:0] num, logic [127:0] den);
         logic [127:0] q;
         q = num / den;
         if (q[127:64] != 0) begin
            clip = 1;
            return '1;
         end
         return q[63:0];
      endfunction

      // scale * r, truncated toward zero, clipped to 32 bits
      function logic [31:0] force_part(logic [30:0] scale, longint d);
         logic [63:0] mag;
         logic [63:0] p;
         mag = (d < 0) ? -d : d;
         p = (64'(scale) * mag) >> 16;
         if (d < 0) begin
            if (p > 64'h8000_0000) begin
               clip = 1;
               p = 64'h8000_0000;
            end
            return 32'(-p);
         end
         if (p > 64'h7FFF_FFFF) begin
            clip = 1;
            p = 64'h7FFF_FFFF;
         end
         return p[31:0];
      endfunction

      // accepted pair: work out its result
      function void note_pair(logic signed [31:0] pos [6]);
         longint            d [3];
         logic [63:0]       a;
         logic [65:0]       sum;
         logic [127:0]      d2, sig2, rc2;
         logic [63:0]       s, s2, s3, s4, s6, s7, coef, t, f, w, w2, u, num;
         ljpf_pkg::rsp_type e;
         sum = 0;
         clip = 0;
         e = '0;
         for (int k = 0; k < 3; k++) begin
            d[k] = longint'(pos[k]) - longint'(pos[k+3]);
            a = (d[k] < 0) ? -d[k] : d[k];
            sum += a * a;
         end
         d2 = sum >> 16;
         sig2 = sigma * sigma;
         rc2 = (sig2 * ljpf_pkg::CUBE_ROOT_TWO_Q30) >> 46;
         e.in_cut = d2 < rc2;
         if (e.in_cut) begin
            if (d2 == 0) begin
               clip = 1;
               s = '1;
            end else begin
               s = div_q32(sig2 << 16, d2);
            end
            s2 = mul_q32(s, s);
            s3 = mul_q32(s2, s);
            s4 = mul_q32(s3, s);
            s6 = mul_q32(s3, s3);
            s7 = mul_q32(s6, s);
            num = 48 * 64'(depth);
            coef = div_q32(128'(num) << 48, sig2);
            // truncation near the cutoff can push this below zero
            t = (s7 > (s4 >> 1)) ? s7 - (s4 >> 1) : 0;
            f = mul_q32(coef, t) >> 16;
            if (f > 64'h7FFF_FFFF) begin
               clip = 1;
               f = 64'h7FFF_FFFF;
            end
            e.fs = f[31:0];
            // eps*(2*s^3 - 1)^2
            if (s3[63]) begin
               clip = 1;
               w = '1;
            end else begin
               w = ((s3 << 1) >= ljpf_pkg::ONE_Q32) ? (s3 << 1) - ljpf_pkg::ONE_Q32
                                                     : ljpf_pkg::ONE_Q32 - (s3 << 1);
            end
            w2 = mul_q32(w, w);
            u = mul_q32(64'(depth), w2);
            if (u > 64'h7FFF_FFFF) begin
               clip = 1;
               u = 64'h7FFF_FFFF;
            end
            e.pot = u[31:0];
            e.fx = force_part(e.fs[30:0], d[0]);
            e.fy = force_part(e.fs[30:0], d[1]);
            e.fz = force_part(e.fs[30:0], d[2]);
         end
         if (d2 > 128'hFFFF_FFFF_FFFF) begin
            clip = 1;
            d2 = 128'hFFFF_FFFF_FFFF;
         end
         e.d2 = d2[47:0];
         e.sat = clip;
         force_q.push_back(e);
      endfunction

      function void check_result(ljpf_pkg::rsp_type got);
         ljpf_pkg::rsp_type e;
         if (force_q.size() == 0) begin
            $error("result item with nothing expected");
            errors++;
            return;
         end
         e = force_q.pop_front();
         checked++;
         inside_seen += e.in_cut;
         sat_seen += e.sat;
         if (got.fx !== e.fx) begin
            $error("force_x expected %0d got %0d", $signed(e.fx), $signed(got.fx));
            errors++;
         end
         if (got.fy !== e.fy) begin
            $error("force_y expected %0d got %0d", $signed(e.fy), $signed(got.fy));
            errors++;
         end
         if (got.fz !== e.fz) begin
            $error("force_z expected %0d got %0d", $signed(e.fz), $signed(got.fz));
            errors++;
         end
         if (got.fs !== e.fs) begin
            $error("force_scale expected %0d got %0d", $signed(e.fs), $signed(got.fs));
            errors++;
         end
         if (got.d2 !== e.d2) begin
            $error("distance_squared expected %0d got %0d", e.d2, got.d2);
            errors++;
         end
         if (got.pot !== e.pot) begin
            $error("pair_potential expected %0d got %0d", $signed(e.pot), $signed(got.pot));
            errors++;
         end
         if (got.in_cut !== e.in_cut) begin
            $error("inside_cutoff expected %0b got %0b", e.in_cut, got.in_cut);
            errors++;
         end
         if (got.sat !== e.sat) begin
            $error("saturated expected %0b got %0b", e.sat, got.sat);
            errors++;
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic signed [31:0] req_first_x = 0;
   logic signed [31:0] req_first_y = 0;
   logic signed [31:0] req_first_z = 0;
   logic signed [31:0] req_second_x = 0;
   logic signed [31:0] req_second_y = 0;
   logic signed [31:0] req_second_z = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic signed [31:0] rsp_force_x;
   logic signed [31:0] rsp_force_y;
   logic signed [31:0] rsp_force_z;
   logic signed [31:0] rsp_force_scale;
   logic [47:0]        rsp_distance_squared;
   logic signed [31:0] rsp_pair_potential;
   logic               rsp_inside_cutoff;
   logic               rsp_saturated;
   logic               csr_write = 0;
   logic               csr_index = ljpf_pkg::REG_LENGTH_SCALE;
   logic [30:0]        csr_wdata = 0;

   ljpf_scoreboard force_sb = new();
   int unsigned    cycles = 0;
   int             sent = 0;
   bit             no_idle = 0;

   lennard_jones_pair_force uut (.*);

   always #6 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side: random stalls, checked at the accepting edge
   initial begin
      int unsigned stall;
      ljpf_pkg::rsp_type got;
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 15);
         if (stall != 0) begin
            rsp_ready <= 0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!(rsp_valid && !reset));
         got = {rsp_force_x, rsp_force_y, rsp_force_z, rsp_force_scale,
                rsp_distance_squared, rsp_pair_potential, rsp_inside_cutoff, rsp_saturated};
         force_sb.check_result(got);
      end
   end

   task automatic send_pair(logic signed [31:0] pos [6]);
      int unsigned gap;
      gap = no_idle ? 0 : $urandom_range(0, 15);
      if (gap != 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_first_x <= pos[0];
      req_first_y <= pos[1];
      req_first_z <= pos[2];
      req_second_x <= pos[3];
      req_second_y <= pos[4];
      req_second_z <= pos[5];
      do @(posedge clock); while (!req_ready);
      force_sb.note_pair(pos);
      sent++;
   endtask

   // pause intake until every expected result is back and the pipeline is empty
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (force_sb.force_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(ljpf_pkg::reg_index_type idx, logic [30:0] value);
      csr_write <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_write <= 0;
      @(posedge clock);
      if (idx == ljpf_pkg::REG_LENGTH_SCALE) force_sb.sigma = value;
      else force_sb.depth = value;
   endtask

   task automatic set_regs(logic [30:0] sig, logic [30:0] eps);
      write_reg(ljpf_pkg::REG_LENGTH_SCALE, sig);
      write_reg(ljpf_pkg::REG_WELL_DEPTH, eps);
      // let the coefficient divider catch up
      repeat (SETTLE) @(posedge clock);
   endtask

   // mostly pairs near the cutoff, scaled by sigma; some fully random noise
   task automatic random_pair();
      logic signed [31:0] pos [6];
      longint span, off;
      int unsigned pick;
      pick = $urandom_range(0, 9);
      for (int k = 0; k < 3; k++) pos[k] = $urandom;
      if (pick < 2) begin
         for (int k = 3; k < 6; k++) pos[k] = $urandom;
      end else begin
         span = longint'(force_sb.sigma);
         if (pick < 4) span = span / 4;
         if (span > 64'd1 << 30) span = 64'd1 << 30;
         for (int k = 0; k < 3; k++) begin
            pos[k] = $signed($urandom) >>> 1;
            off = longint'($urandom_range(0, 32'(span))) - longint'($urandom_range(0, 32'(span)));
            pos[k+3] = pos[k] - 32'(off);
         end
      end
      send_pair(pos);
   endtask

   task automatic directed_pairs();
      logic signed [31:0] pos [6];
      logic signed [31:0] mx, mn;
      mx = 32'sh7FFF_FFFF;
      mn = 32'sh8000_0000;
      // zero distance
      pos = '{32'sd100, -32'sd5, 32'sd0, 32'sd100, -32'sd5, 32'sd0};
      send_pair(pos);
      // largest separation, distance clips
      pos = '{mx, mx, mx, mn, mn, mn};
      send_pair(pos);
      pos = '{mn, mn, mn, mx, mx, mx};
      send_pair(pos);
      // just outside the cutoff and well inside it along each axis, both signs
      foreach (pos[i]) pos[i] = 0;
      for (int k = 0; k < 3; k++) begin
         pos[k] = 32'sd73562;
         send_pair(pos);
         pos[k] = -32'sd73563;
         send_pair(pos);
         pos[k] = 32'sd73600;
         send_pair(pos);
         pos[k] = -32'sd20000;
         send_pair(pos);
         pos[k] = 0;
      end
      // at r equal to sigma and deep inside
      pos = '{32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0};
      send_pair(pos);
      pos = '{32'sd1, -32'sd1, 32'sd1, 32'sd0, 32'sd0, 32'sd0};
      send_pair(pos);
      pos = '{mx, 32'sd0, mn, mx, 32'sd1, mn};
      send_pair(pos);
   endtask

   initial begin
      logic [30:0] sig_set [7];
      logic [30:0] eps_set [7];
      int per_phase;
      repeat (3) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      directed_pairs();
      drain();

      // settings: reset values, extremes, zero sigma, two fixed mixes, then random
      sig_set = '{Q_ONE, 31'd1, REG_MAX, 31'd0, 31'd200000, 31'd3000, 31'($urandom)};
      eps_set = '{Q_ONE, 31'd0, REG_MAX, Q_ONE, 31'd1, REG_MAX, 31'($urandom)};
      per_phase = 150;
      for (int ph = 0; ph < 7; ph++) begin
         set_regs(sig_set[ph], eps_set[ph]);
         no_idle = (ph % 3 == 2);
         for (int n = 0; n < per_phase; n++) begin
            random_pair();
            if (ph == 0 && n == 70) drain();
         end
         drain();
      end

      $display("Sent %0d pairs over 7 settings of sigma and epsilon; checked %0d results,",
               sent, force_sb.checked);
      $display("%0d inside the cutoff, %0d flagged saturated.",
               force_sb.inside_seen, force_sb.sat_seen);
      if (force_sb.errors == 0 && force_sb.force_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
